/* sv/pkcs1c_pkg.sv */
// Shared types and constants for the PKCS#1 v1.5 padding checker.
`default_nettype none

package pkcs1c_pkg;

  localparam int MAX_BLOCK_BYTES = 512;
  localparam logic [9:0] PAD_OVERHEAD = 10'd11;
  localparam logic [9:0] MIN_PAD = 10'd8;
  localparam logic [9:0] COUNT_MAX = 10'h3FF;
  localparam logic [7:0] SEP_BYTE = 8'h00;
  localparam logic [7:0] PAD_FF = 8'hFF;

  localparam logic [1:0] BT_SIGN = 2'd1;
  localparam logic [1:0] BT_CRYPT = 2'd2;

  typedef enum logic [1:0] {
    CFG_BLOCK_TYPE    = 2'd0,
    CFG_MODULUS_BYTES = 2'd1,
    CFG_OUT_CAPACITY  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_KEY_SMALL   = 4'd1,
    ST_BAD_LEAD    = 4'd2,
    ST_BAD_TYPE    = 4'd3,
    ST_BAD_PAD     = 4'd4,
    ST_NO_SEP      = 4'd5,
    ST_SHORT_PAD   = 4'd6,
    ST_TOO_LARGE   = 4'd7,
    ST_BAD_LENGTHS = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_TYPE = 3'd1,
    PH_PAD  = 3'd2,
    PH_DATA = 3'd3,
    PH_WAIT = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] block_type;
    logic [9:0] modulus_bytes;
    logic [9:0] out_capacity;
  } cfg_t;

  typedef struct packed {
    logic       has_result;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       done_res;
    status_t    status;
    logic [9:0] payload_len;
  } res_t;

endpackage

`default_nettype wire

/* sv/pkcs1c_cfg.sv */
// Configuration register file: block type, modulus length and output capacity.
`default_nettype none

module pkcs1c_cfg
  import pkcs1c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_type    <= BT_CRYPT;
      cfg_r.modulus_bytes <= 10'd256;
      cfg_r.out_capacity  <= 10'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCK_TYPE:    cfg_r.block_type    <= cfg_data[1:0];
        CFG_MODULUS_BYTES: cfg_r.modulus_bytes <= cfg_data;
        CFG_OUT_CAPACITY:  cfg_r.out_capacity  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/pkcs1c_core.sv */
// Per-byte check state and the single-pass padding check logic.
`default_nettype none

module pkcs1c_core
  import pkcs1c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       adv,
  input  wire logic [7:0] item_byte,
  input  wire logic [9:0] item_len,
  input  wire logic       item_last,
  output res_t            res
);

  phase_t     phase_r, phase_nxt, phase0;
  status_t    err_r, err_nxt, err_start, err0, err1;
  logic [9:0] byte_index_r, byte_index_nxt;
  logic [9:0] pad_count_r, pad_count_nxt, pad0;
  logic [9:0] payload_left_r, payload_left_nxt, left0, left_dec;
  logic [9:0] blk_total_r, blk_eff;
  logic [9:0] pay_total_r, pay_total_nxt, ptot0;
  logic [9:0] pay_room;
  logic [10:0] pos_p1, len_w, num_w;
  logic       first, final_byte, emit;

  assign first  = (byte_index_r == 10'd0);
  assign pos_p1 = {1'b0, byte_index_r} + 11'd1;
  assign len_w  = {1'b0, item_len};
  assign num_w  = {1'b0, cfg.modulus_bytes};

  // start-of-block checks, first failing one wins
  always_comb begin
    if (cfg.block_type == BT_CRYPT && (cfg.out_capacity == 10'd0 || item_len == 10'd0))
      err_start = ST_BAD_LENGTHS;
    else if (cfg.modulus_bytes < PAD_OVERHEAD)
      err_start = ST_KEY_SMALL;
    else if (cfg.block_type == BT_CRYPT && item_len > cfg.modulus_bytes)
      err_start = ST_BAD_LENGTHS;
    else if (len_w > 11'(MAX_BLOCK_BYTES))
      err_start = ST_BAD_LENGTHS;
    else if (num_w != len_w && num_w != len_w + 11'd1)
      err_start = ST_BAD_TYPE;
    else
      err_start = ST_OK;
  end

  assign blk_eff = first ? item_len : blk_total_r;
  assign err0    = first ? err_start : err_r;
  assign phase0  = first ? ((cfg.modulus_bytes == item_len) ? PH_LEAD : PH_TYPE) : phase_r;
  assign pad0    = first ? 10'd0 : pad_count_r;
  assign left0   = first ? 10'd0 : payload_left_r;
  assign ptot0   = first ? 10'd0 : pay_total_r;

  // byte count checks against the latched block length
  always_comb begin
    err1 = err0;
    if (err1 == ST_OK && byte_index_r >= blk_eff)
      err1 = ST_BAD_LENGTHS;
    if (err1 == ST_OK && item_last && pos_p1 < {1'b0, blk_eff})
      err1 = ST_BAD_LENGTHS;
  end

  assign final_byte = (pos_p1 == {1'b0, blk_eff});
  assign pay_room   = blk_eff - byte_index_r - 10'd1;
  assign left_dec   = (left0 != 10'd0) ? left0 - 10'd1 : left0;

  // next state
  always_comb begin
    phase_nxt        = phase0;
    err_nxt          = err1;
    pad_count_nxt    = pad0;
    payload_left_nxt = left0;
    pay_total_nxt    = ptot0;
    if (err1 == ST_OK) begin
      unique case (phase0)
        PH_LEAD: begin
          if (item_byte != SEP_BYTE) err_nxt = ST_BAD_LEAD;
          else                       phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          if ((cfg.block_type != BT_SIGN && cfg.block_type != BT_CRYPT) ||
              item_byte != {6'd0, cfg.block_type})
            err_nxt = ST_BAD_TYPE;
          else if (final_byte)
            err_nxt = ST_NO_SEP;
          else
            phase_nxt = PH_PAD;
        end
        PH_PAD: begin
          if (item_byte == SEP_BYTE) begin
            if (pad0 < MIN_PAD) begin
              err_nxt = ST_SHORT_PAD;
            end else if (pay_room > cfg.out_capacity) begin
              err_nxt = ST_TOO_LARGE;
            end else begin
              pay_total_nxt    = pay_room;
              payload_left_nxt = pay_room;
              phase_nxt        = (pay_room != 10'd0) ? PH_DATA : PH_WAIT;
            end
          end else if (cfg.block_type == BT_SIGN && item_byte != PAD_FF) begin
            err_nxt = ST_BAD_PAD;
          end else begin
            if (pad0 < COUNT_MAX) pad_count_nxt = pad0 + 10'd1;
            if (final_byte) err_nxt = ST_NO_SEP;
          end
        end
        PH_DATA: begin
          payload_left_nxt = left_dec;
          if (left_dec == 10'd0) phase_nxt = PH_WAIT;
        end
        PH_WAIT: ;
        default: ;
      endcase
    end
    // block ends: rewind for the next one
    if (item_last) begin
      phase_nxt        = PH_LEAD;
      pad_count_nxt    = 10'd0;
      payload_left_nxt = 10'd0;
    end
  end

  assign byte_index_nxt = item_last ? 10'd0 :
                          (byte_index_r < COUNT_MAX) ? pos_p1[9:0] : COUNT_MAX;

  // outputs
  always_comb begin
    emit             = (err1 == ST_OK) && (phase0 == PH_DATA);
    res.has_result   = emit || item_last;
    res.has_payload  = emit;
    res.payload_byte = emit ? item_byte : 8'd0;
    res.done_res     = item_last;
    res.status       = item_last ? err_nxt : ST_OK;
    res.payload_len  = (item_last && err_nxt == ST_OK) ? pay_total_nxt : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LEAD;
      err_r          <= ST_OK;
      byte_index_r   <= 10'd0;
      pad_count_r    <= 10'd0;
      payload_left_r <= 10'd0;
      blk_total_r    <= 10'd0;
      pay_total_r    <= 10'd0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      err_r          <= err_nxt;
      byte_index_r   <= byte_index_nxt;
      pad_count_r    <= pad_count_nxt;
      payload_left_r <= payload_left_nxt;
      blk_total_r    <= blk_eff;
      pay_total_r    <= pay_total_nxt;
    end
  end

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_last |=> byte_index_r == 10'd0 && phase_r == PH_LEAD)
    else $error("block end did not rewind the byte position");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !item_last && byte_index_r != COUNT_MAX |=>
      byte_index_r == $past(byte_index_r) + 10'd1)
    else $error("byte position did not advance by one");

  a_data_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> payload_left_r != 10'd0)
    else $error("data phase with no payload bytes left");

  a_payload_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.has_payload |-> phase_r == PH_DATA && byte_index_r != 10'd0)
    else $error("payload byte outside the data phase");

endmodule

`default_nettype wire

/* sv/pkcs1_padding_checker.sv */
// Top level of the PKCS#1 v1.5 padding checker: input register, check core, result register.
//
// Usage: feed the decrypted RSA block one byte per transfer on the in_ channel,
// in order, with in_block_len the same on every byte and in_is_last on the final
// byte. The out_ channel gives one transfer per recovered payload byte
// (out_has_payload) and one for the final byte (out_done_res with out_status and
// out_payload_len); other bytes give no transfer. Both channels use valid/stall;
// a transfer happens when valid is high and stall is low.
// A result passes through the input register and then the result register; throughput is
// one byte per cycle while out_stall is low, set by the single register-to-register check pass.
// The cfg_ channel writes block type, modulus length and output capacity by
// index; cfg_ready is always high. Write only while no block is in flight.
// Reset (rst_n low, synchronous) empties both registers, restores the
// configuration defaults and rewinds to the start of a block.
// When out_stall is high the held result stays put, the input register fills
// and then in_stall rises until the result drains.
`default_nettype none

module pkcs1_padding_checker
  import pkcs1c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_block_byte,
  input  wire logic [9:0] in_block_len,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_has_payload,
  output logic [7:0]      out_payload_byte,
  output logic            out_done_res,
  output logic [3:0]      out_status,
  output logic [9:0]      out_payload_len,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [9:0] s1_len_r;
  logic       s1_last_r;
  logic       out_free, adv;
  logic       out_valid_r;
  res_t       out_r;

  pkcs1c_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pkcs1c_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .adv       (adv),
    .item_byte (s1_byte_r),
    .item_len  (s1_len_r),
    .item_last (s1_last_r),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !adv;

  // input register: refill whenever the held byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_block_byte;
      s1_len_r  <= in_block_len;
      s1_last_r <= in_is_last;
    end
  end

  // result register: hold while stalled, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.has_result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_payload  = out_r.has_payload;
  assign out_payload_byte = out_r.payload_byte;
  assign out_done_res     = out_r.done_res;
  assign out_status       = out_r.status;
  assign out_payload_len  = out_r.payload_len;

endmodule

`default_nettype wire
